### rtl/sbfls_pkg.sv
// shared types and constants for the source byte filter and line splicer
package sbfls_pkg;

  // width of the input and kept-stream position counters
  localparam int unsigned PosBits = 32;
  // width of the reported error position
  localparam int unsigned ErrPosBits = 32;
  // most results one input byte can cause
  localparam int unsigned MaxRes = 3;
  localparam int unsigned ResCntBits = $clog2(MaxRes + 1);
  localparam int unsigned ResIdxBits = $clog2(MaxRes);

  // status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNonAscii = 2'd1;
  localparam logic [1:0] StatusBsAtEnd  = 2'd2;

  // byte codes
  localparam logic [7:0] ByteFirstHigh = 8'd127;
  localparam logic [7:0] ByteFirstText = 8'd32;
  localparam logic [7:0] ByteTab       = 8'd9;
  localparam logic [7:0] ByteNewline   = 8'd10;
  localparam logic [7:0] ByteBackslash = 8'h5c;

  typedef logic [PosBits-1:0] pos_t;

  // one result item
  typedef struct packed {
    logic                  out_valid;
    logic [6:0]            out_char;
    logic [1:0]            status;
    logic [ErrPosBits-1:0] error_position;
    logic                  run_last;
    logic                  stream_done;
  } res_t;

  // all results of one input byte
  typedef struct packed {
    logic [ResCntBits-1:0] cnt;
    res_t [MaxRes-1:0]     res;
  } batch_t;

endpackage

### rtl/sbfls_in_if.sv
// input channel: raw source bytes with end-of-file mark
interface sbfls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       file_end;

  modport source (output valid, output in_byte, output file_end, input ready);
  modport sink (input valid, input in_byte, input file_end, output ready);
endinterface

### rtl/sbfls_out_if.sv
// output channel: filtered and spliced result items
interface sbfls_out_if;
  logic                            valid;
  logic                            ready;
  logic                            out_valid;
  logic [6:0]                      out_char;
  logic [1:0]                      status;
  logic [sbfls_pkg::ErrPosBits-1:0] error_position;
  logic                            run_last;
  logic                            stream_done;

  modport source (output valid, output out_valid, output out_char, output status,
                  output error_position, output run_last, output stream_done,
                  input ready);
  modport sink (input valid, input out_valid, input out_char, input status,
                input error_position, input run_last, input stream_done,
                output ready);
endinterface

### rtl/sbfls_core.sv
// per-byte filter and splice logic with the file state registers
module sbfls_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [7:0]          in_byte_i,
  input  logic                file_end_i,
  output sbfls_pkg::batch_t   batch_o
);

  sbfls_pkg::pos_t input_index_q, input_index_d;
  sbfls_pkg::pos_t kept_index_q, kept_index_d;
  logic held_bs_q, held_bs_d;
  logic last_nl_q, last_nl_d;
  logic last_splice_q, last_splice_d;
  logic err_q, err_d;

  // build the results of one byte and the next file state
  always_comb begin
    sbfls_pkg::res_t [sbfls_pkg::MaxRes-1:0] res;
    logic [sbfls_pkg::ResCntBits-1:0]       cnt;
    logic [6:0]                             emit_ch;
    logic                                   emit_vld;
    logic [1:0]                             emit_st;
    sbfls_pkg::pos_t                        emit_pos;
    logic                                   keep;
    logic                                   nonascii;
    logic                                   emit_bs;
    logic                                   emit_byte;
    logic                                   emit_end;

    res          = '0;
    cnt          = '0;
    input_index_d = input_index_q + sbfls_pkg::PosBits'(1);
    kept_index_d = kept_index_q;
    held_bs_d    = held_bs_q;
    last_nl_d    = last_nl_q;
    last_splice_d = last_splice_q;
    err_d        = err_q;
    emit_bs      = 1'b0;
    emit_byte    = 1'b0;
    emit_end     = 1'b0;
    emit_vld     = 1'b0;
    emit_ch      = '0;
    emit_st      = sbfls_pkg::StatusOk;
    emit_pos     = '0;

    nonascii = (in_byte_i >= sbfls_pkg::ByteFirstHigh);
    keep     = !nonascii && !(in_byte_i < sbfls_pkg::ByteFirstText &&
                              in_byte_i != sbfls_pkg::ByteTab &&
                              in_byte_i != sbfls_pkg::ByteNewline);

    // filter and splice
    if (!err_q) begin
      if (nonascii) begin
        err_d     = 1'b1;
        held_bs_d = 1'b0;
      end else if (keep) begin
        kept_index_d = kept_index_q + sbfls_pkg::PosBits'(1);
        if (held_bs_q) begin
          if (in_byte_i == sbfls_pkg::ByteNewline) begin
            held_bs_d     = 1'b0;
            last_splice_d = 1'b1;
            last_nl_d     = 1'b1;
          end else begin
            emit_bs = 1'b1;
            if (in_byte_i != sbfls_pkg::ByteBackslash) begin
              held_bs_d = 1'b0;
              emit_byte = 1'b1;
            end
            last_splice_d = 1'b0;
            last_nl_d     = 1'b0;
          end
        end else begin
          if (in_byte_i == sbfls_pkg::ByteBackslash) begin
            held_bs_d = 1'b1;
          end else begin
            emit_byte = 1'b1;
          end
          last_splice_d = 1'b0;
          last_nl_d     = (in_byte_i == sbfls_pkg::ByteNewline);
        end
      end
    end

    // non-ascii error result
    if (!err_q && nonascii) begin
      res[cnt].status         = sbfls_pkg::StatusNonAscii;
      res[cnt].error_position = sbfls_pkg::ErrPosBits'(input_index_q);
      cnt = cnt + sbfls_pkg::ResCntBits'(1);
    end
    // released backslash
    if (emit_bs) begin
      res[cnt].out_valid = 1'b1;
      res[cnt].out_char  = sbfls_pkg::ByteBackslash[6:0];
      cnt = cnt + sbfls_pkg::ResCntBits'(1);
    end
    // kept byte
    if (emit_byte) begin
      res[cnt].out_valid = 1'b1;
      res[cnt].out_char  = in_byte_i[6:0];
      cnt = cnt + sbfls_pkg::ResCntBits'(1);
    end

    // end-of-file handling
    if (file_end_i) begin
      if (!err_d) begin
        if (held_bs_d) begin
          emit_end = 1'b1;
          emit_st  = sbfls_pkg::StatusBsAtEnd;
          emit_pos = kept_index_d - sbfls_pkg::PosBits'(1);
        end else if (last_splice_d) begin
          emit_end = 1'b1;
          emit_st  = sbfls_pkg::StatusBsAtEnd;
          emit_pos = kept_index_d - sbfls_pkg::PosBits'(2);
        end else if (kept_index_d != '0 && !last_nl_d) begin
          emit_end = 1'b1;
          emit_vld = 1'b1;
          emit_ch  = sbfls_pkg::ByteNewline[6:0];
        end
      end
      if (cnt == '0) begin
        emit_end = 1'b1;
      end
      if (emit_end && cnt != sbfls_pkg::ResCntBits'(sbfls_pkg::MaxRes)) begin
        res[cnt].out_valid      = emit_vld;
        res[cnt].out_char       = emit_ch;
        res[cnt].status         = emit_st;
        res[cnt].error_position = sbfls_pkg::ErrPosBits'(emit_pos);
        cnt = cnt + sbfls_pkg::ResCntBits'(1);
      end
      res[cnt - sbfls_pkg::ResCntBits'(1)].stream_done = 1'b1;
      input_index_d = '0;
      kept_index_d  = '0;
      held_bs_d     = 1'b0;
      last_nl_d     = 1'b0;
      last_splice_d = 1'b0;
      err_d         = 1'b0;
    end

    // mark the last result of this byte
    if (cnt != '0) begin
      res[cnt - sbfls_pkg::ResCntBits'(1)].run_last = 1'b1;
    end

    batch_o.cnt = cnt;
    batch_o.res = res;
  end

  // file state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_index_q <= '0;
      kept_index_q  <= '0;
      held_bs_q     <= 1'b0;
      last_nl_q     <= 1'b0;
      last_splice_q <= 1'b0;
      err_q         <= 1'b0;
    end else if (advance_i) begin
      input_index_q <= input_index_d;
      kept_index_q  <= kept_index_d;
      held_bs_q     <= held_bs_d;
      last_nl_q     <= last_nl_d;
      last_splice_q <= last_splice_d;
      err_q         <= err_d;
    end
  end

endmodule

### rtl/sbfls_obuf.sv
// result register holding the results of one byte, sent one per transfer
module sbfls_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  sbfls_pkg::batch_t batch_i,
  output logic              can_load_o,
  sbfls_out_if.source       out_o
);

  logic                                buf_vld_q;
  sbfls_pkg::batch_t                   batch_q;
  logic [sbfls_pkg::ResIdxBits-1:0]    idx_q;
  logic                                take;
  logic                                last;
  sbfls_pkg::res_t                     cur;

  assign take       = buf_vld_q && out_o.ready;
  assign last       = (sbfls_pkg::ResCntBits'(idx_q) ==
                       batch_q.cnt - sbfls_pkg::ResCntBits'(1));
  assign can_load_o = !buf_vld_q || (take && last);
  assign cur        = batch_q.res[idx_q];

  // drive the output channel from the current entry
  assign out_o.valid          = buf_vld_q;
  assign out_o.out_valid      = cur.out_valid;
  assign out_o.out_char       = cur.out_char;
  assign out_o.status         = cur.status;
  assign out_o.error_position = cur.error_position;
  assign out_o.run_last       = cur.run_last;
  assign out_o.stream_done    = cur.stream_done;

  // control: load a new batch or step through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (load_i) begin
      buf_vld_q <= (batch_i.cnt != '0);
      idx_q     <= '0;
    end else if (take) begin
      if (last) begin
        buf_vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + sbfls_pkg::ResIdxBits'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      batch_q <= batch_i;
    end
  end

endmodule

### rtl/source_byte_filter_line_splicer.sv
// top level of the source byte filter and line splicer
// path: input register, combinational filter and splice core, result register
// throughput: one byte per cycle while each byte gives at most one result and the output is ready;
//   a byte with several results holds the input at the result register until its last result is taken
// reset: asynchronous active low, clears the file state and both stage valids
// no clearing pass: the block is ready for input as soon as reset is released
module source_byte_filter_line_splicer (
  input  logic         clk_i,
  input  logic         rst_ni,
  sbfls_in_if.sink     in_i,
  sbfls_out_if.source  out_o
);

  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  logic              file_end_q;
  logic              can_load;
  logic              consume;
  sbfls_pkg::batch_t batch;

  assign in_i.ready = !in_vld_q || can_load;
  assign consume    = in_vld_q && can_load;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q  <= in_i.in_byte;
      file_end_q <= in_i.file_end;
    end
  end

  // filter and splice
  sbfls_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (consume),
    .in_byte_i  (in_byte_q),
    .file_end_i (file_end_q),
    .batch_o    (batch)
  );

  // result register
  sbfls_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (consume),
    .batch_i    (batch),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

### verif/sbfls_splice_checker.sv
// checker for the byte filter and line splicer: predicts results and compares transfers
module sbfls_splice_checker
  import sbfls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sbfls_in_if         byte_mon_i,
  sbfls_out_if        res_mon_i,
  output int          mismatch_cnt_o,
  output int          due_cnt_o
);

  // predictor copy of the per-file state
  pos_t in_pos;
  pos_t kept_pos;
  logic bs_held;
  logic nl_last;
  logic splice_last;
  logic err_seen;

  // results still to come, oldest first
  res_t due_results[$];
  res_t want;

  task automatic clear_file_state();
    in_pos      = '0;
    kept_pos    = '0;
    bs_held     = 1'b0;
    nl_last     = 1'b0;
    splice_last = 1'b0;
    err_seen    = 1'b0;
  endtask

  function automatic res_t mk_res(logic ov, logic [6:0] ch, logic [1:0] st, pos_t pos);
    res_t r;
    r                = '0;
    r.out_valid      = ov;
    r.out_char       = ch;
    r.status         = st;
    r.error_position = pos[ErrPosBits-1:0];
    return r;
  endfunction

  // work out the results of one raw byte and queue them
  task automatic filter_and_splice(input logic [7:0] b, input logic fe);
    res_t run [MaxRes];
    int   n;
    n = 0;
    if (!err_seen) begin
      if (b >= ByteFirstHigh) begin
        // non-ascii byte: report it, drop any held backslash, ignore the rest of the file
        run[n] = mk_res(1'b0, 7'd0, StatusNonAscii, in_pos);
        n++;
        err_seen = 1'b1;
        bs_held  = 1'b0;
      end else if (b < ByteFirstText && b != ByteTab && b != ByteNewline) begin
        // control byte is dropped
      end else begin
        kept_pos = kept_pos + pos_t'(1);
        if (bs_held && b == ByteNewline) begin
          // backslash-newline vanishes
          bs_held     = 1'b0;
          splice_last = 1'b1;
          nl_last     = 1'b1;
        end else if (bs_held) begin
          run[n] = mk_res(1'b1, ByteBackslash[6:0], StatusOk, '0);
          n++;
          if (b != ByteBackslash) begin
            bs_held = 1'b0;
            run[n]  = mk_res(1'b1, b[6:0], StatusOk, '0);
            n++;
          end
          splice_last = 1'b0;
          nl_last     = 1'b0;
        end else begin
          if (b == ByteBackslash) begin
            bs_held = 1'b1;
          end else begin
            run[n] = mk_res(1'b1, b[6:0], StatusOk, '0);
            n++;
          end
          splice_last = 1'b0;
          nl_last     = (b == ByteNewline);
        end
      end
    end
    in_pos = in_pos + pos_t'(1);

    // end of file: backslash error, appended newline or bare marker
    if (fe) begin
      if (!err_seen) begin
        if (bs_held) begin
          run[n] = mk_res(1'b0, 7'd0, StatusBsAtEnd, kept_pos - pos_t'(1));
          n++;
        end else if (splice_last) begin
          run[n] = mk_res(1'b0, 7'd0, StatusBsAtEnd, kept_pos - pos_t'(2));
          n++;
        end else if (kept_pos != '0 && !nl_last) begin
          run[n] = mk_res(1'b1, ByteNewline[6:0], StatusOk, '0);
          n++;
        end
      end
      if (n == 0) begin
        run[n] = mk_res(1'b0, 7'd0, StatusOk, '0);
        n++;
      end
      run[n-1].stream_done = 1'b1;
      clear_file_state();
    end

    if (n > 0) begin
      run[n-1].run_last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      due_results.push_back(run[i]);
    end
  endtask

  task automatic check_field(input string fname, input longint unsigned exp_val,
                             input longint unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", fname, exp_val, act_val);
      mismatch_cnt_o++;
    end
  endtask

  // compare result transfers first, then predict from the byte transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_file_state();
      due_results.delete();
      mismatch_cnt_o = 0;
      due_cnt_o      = 0;
    end else begin
      if (res_mon_i.valid && res_mon_i.ready) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing expected: out_valid %0d out_char %0d status %0d",
                 res_mon_i.out_valid, res_mon_i.out_char, res_mon_i.status);
          mismatch_cnt_o++;
        end else begin
          want = due_results.pop_front();
          check_field("out_valid", want.out_valid, res_mon_i.out_valid);
          check_field("out_char", want.out_char, res_mon_i.out_char);
          check_field("status", want.status, res_mon_i.status);
          check_field("error_position", want.error_position, res_mon_i.error_position);
          check_field("run_last", want.run_last, res_mon_i.run_last);
          check_field("stream_done", want.stream_done, res_mon_i.stream_done);
        end
      end
      if (byte_mon_i.valid && byte_mon_i.ready) begin
        filter_and_splice(byte_mon_i.in_byte, byte_mon_i.file_end);
      end
      due_cnt_o = due_results.size();
    end
  end

endmodule

### verif/source_byte_filter_line_splicer_test.sv
// testbench top for the byte filter and line splicer: clock, reset, stimulus and verdict
module source_byte_filter_line_splicer_test;
  import sbfls_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomItems = 310;
  localparam int HoldCycles = 60;

  // opening files, each entry is {file_end, byte}
  localparam logic [8:0] OpeningRun [24] = '{
    9'h000,  // dropped control byte, all zeros
    9'h020,  // lowest printable
    9'h009,  // tab kept
    9'h07e,  // highest printable
    9'h05c,  // backslash held
    9'h05c,  // second backslash releases the first
    9'h01f,  // control byte dropped while a backslash is held
    9'h00a,  // splice
    9'h05c,
    9'h041,  // held backslash released with a letter
    9'h10a,  // newline ends the file, nothing appended
    9'h15c,  // lone backslash at end of file
    9'h078,
    9'h05c,
    9'h10a,  // splice at end of file
    9'h05c,
    9'h07f,  // non-ascii drops the held backslash
    9'h062,  // ignored after the error
    9'h1ff,  // all ones, file end after an error
    9'h101,  // empty kept stream
    9'h071,
    9'h180,  // non-ascii byte ends the file
    9'h05c,
    9'h163   // backslash, letter and appended newline
  };

  logic clk_i;
  logic rst_ni;
  int   mismatch_cnt;
  int   due_cnt;
  int   cycle_cnt = 0;
  int   sent_cnt;
  bit   no_idle;
  bit   hold_req;
  bit   hold_done;

  sbfls_in_if  byte_ch ();
  sbfls_out_if res_ch ();

  source_byte_filter_line_splicer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (res_ch)
  );

  sbfls_splice_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_mon_i     (byte_ch),
    .res_mon_i      (res_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .due_cnt_o      (due_cnt)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("source_byte_filter_line_splicer: mismatch");
      $finish;
    end
  end

  // offer one byte after a random gap and wait for its transfer
  task automatic send_byte(input logic [7:0] b, input logic fe);
    int gap;
    gap = (no_idle || (hold_req && !hold_done)) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      @(negedge clk_i) byte_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    byte_ch.valid    <= 1'b1;
    byte_ch.in_byte  <= b;
    byte_ch.file_end <= fe;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    // count every byte transfer
    sent_cnt++;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        @(negedge clk_i) res_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        @(negedge clk_i) res_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i) res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
    end
  end

  // byte side: reset, opening files, random files, drain and verdict
  initial begin
    int         len;
    int         r;
    logic [7:0] b;
    bit         noise;
    bit         paused;
    rst_ni           = 1'b0;
    byte_ch.valid    = 1'b0;
    byte_ch.in_byte  = '0;
    byte_ch.file_end = 1'b0;
    no_idle          = 1'b0;
    hold_req         = 1'b0;
    hold_done        = 1'b0;
    sent_cnt         = 0;
    paused           = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (OpeningRun[i]) begin
      send_byte(OpeningRun[i][7:0], OpeningRun[i][8]);
    end

    // random files, mostly well-formed text with splices, some pure noise
    sent_cnt = 0;
    while (sent_cnt < RandomItems) begin
      len   = $urandom_range(1, 16);
      noise = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < len; k++) begin
        no_idle = ((sent_cnt / 40) % 3 == 2);
        if (sent_cnt >= 100) begin
          hold_req = 1'b1;
        end
        // let everything drain once mid-run
        if (sent_cnt >= 200 && !paused) begin
          paused = 1'b1;
          @(negedge clk_i) byte_ch.valid <= 1'b0;
          while (due_cnt != 0) @(negedge clk_i);
        end
        if (noise) begin
          b = $urandom_range(0, 255);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            b = $urandom_range(32, 126);
          end else if (r < 60) begin
            b = ByteNewline;
          end else if (r < 78) begin
            b = ByteBackslash;
          end else if (r < 84) begin
            b = ByteTab;
          end else if (r < 90) begin
            b = $urandom_range(0, 31);
          end else if (r < 93) begin
            b = $urandom_range(127, 255);
          end else begin
            // backslash-newline pair
            send_byte(ByteBackslash, 1'b0);
            b = ByteNewline;
          end
        end
        send_byte(b, k == len - 1);
      end
    end

    // wait for every expected result, then report the verdict
    @(negedge clk_i) byte_ch.valid <= 1'b0;
    while (due_cnt != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatch_cnt == 0 && due_cnt == 0) begin
      $display("source_byte_filter_line_splicer: match");
    end else begin
      $display("source_byte_filter_line_splicer: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sbfls_pkg.sv
rtl/sbfls_in_if.sv
rtl/sbfls_out_if.sv
rtl/sbfls_core.sv
rtl/sbfls_obuf.sv
rtl/source_byte_filter_line_splicer.sv
verif/sbfls_splice_checker.sv
verif/source_byte_filter_line_splicer_test.sv
